### hw/rtl/vhau_pkg.sv
`timescale 1ns / 1ps

package vhau_pkg;

   localparam int COORD_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int GUARD_BITS   = 20;
   localparam int UV_W         = COORD_BITS + 1;
   localparam int DP_W         = COORD_BITS + GUARD_BITS + 3;
   localparam int Z_W          = 26;
   localparam int HEAD_W       = 17;
   localparam int DROP_BITS    = 8;
   localparam int ZR_W         = Z_W - DROP_BITS;

   localparam logic signed [Z_W-1:0]    DEG90_Q16  = Z_W'(5898240);
   localparam logic signed [Z_W-1:0]    ROUND_Q16  = Z_W'(128);
   localparam logic signed [HEAD_W-1:0] DEG180_Q8  = HEAD_W'(46080);
   localparam logic signed [HEAD_W-1:0] NEG180_Q8  = -HEAD_W'(46080);
   localparam logic signed [HEAD_W-1:0] NEG_SAT_Q8 = -HEAD_W'(46079);
   localparam logic signed [HEAD_W-1:0] DEG90_Q8   = HEAD_W'(23040);
   localparam logic signed [HEAD_W-1:0] NEG90_Q8   = -HEAD_W'(23040);
   localparam logic signed [HEAD_W-1:0] ZERO_Q8    = '0;

   typedef struct packed {
      logic                     special;
      logic                     zero;
      logic signed [HEAD_W-1:0] fixed_q8;
      logic signed [UV_W-1:0]   u;
      logic signed [UV_W-1:0]   v;
      logic signed [Z_W-1:0]    z;
   } queue_item_type;

   typedef struct packed {
      logic                     special;
      logic                     zero;
      logic signed [HEAD_W-1:0] fixed_q8;
      logic signed [DP_W-1:0]   u;
      logic signed [DP_W-1:0]   v;
      logic signed [Z_W-1:0]    z;
   } stage_type;

   function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         0:       r = Z_W'(2949120);
         1:       r = Z_W'(1740967);
         2:       r = Z_W'(919879);
         3:       r = Z_W'(466945);
         4:       r = Z_W'(234379);
         5:       r = Z_W'(117304);
         6:       r = Z_W'(58666);
         7:       r = Z_W'(29335);
         8:       r = Z_W'(14668);
         9:       r = Z_W'(7334);
         10:      r = Z_W'(3667);
         11:      r = Z_W'(1833);
         12:      r = Z_W'(917);
         13:      r = Z_W'(458);
         14:      r = Z_W'(229);
         15:      r = Z_W'(115);
         16:      r = Z_W'(57);
         17:      r = Z_W'(29);
         18:      r = Z_W'(14);
         19:      r = Z_W'(7);
         20:      r = Z_W'(4);
         21:      r = Z_W'(2);
         22:      r = Z_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/vhau_if.sv
`timescale 1ns / 1ps

interface vhau_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [vhau_pkg::COORD_BITS-1:0] x_coord;
   logic signed [vhau_pkg::COORD_BITS-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface vhau_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [vhau_pkg::HEAD_W-1:0] heading_deg_q8;
   logic                              zero_vector;

   modport source (output valid, output heading_deg_q8, output zero_vector, input ready);
   modport sink   (input valid, input heading_deg_q8, input zero_vector, output ready);
endinterface

### hw/rtl/vhau_front.sv
`timescale 1ns / 1ps

module vhau_front (
   vhau_req_if.sink                  req_chan,
   output logic                      push_valid,
   input  logic                      push_ready,
   output vhau_pkg::queue_item_type  push_item
);

   logic signed [vhau_pkg::UV_W-1:0] xs;
   logic signed [vhau_pkg::UV_W-1:0] ys;
   logic signed [vhau_pkg::UV_W-1:0] u0;
   logic signed [vhau_pkg::UV_W-1:0] v0;
   logic                             x_zero;
   logic                             y_zero;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;

   always_comb begin
      xs     = vhau_pkg::UV_W'(req_chan.x_coord);
      ys     = vhau_pkg::UV_W'(req_chan.y_coord);
      u0     = -ys;
      v0     = xs;
      x_zero = (req_chan.x_coord == '0);
      y_zero = (req_chan.y_coord == '0);

      push_item.zero     = x_zero && y_zero;
      push_item.special  = x_zero || y_zero;
      push_item.fixed_q8 = vhau_pkg::ZERO_Q8;
      if (x_zero && !y_zero) begin
         push_item.fixed_q8 = ys[vhau_pkg::UV_W-1] ? vhau_pkg::ZERO_Q8 : vhau_pkg::DEG180_Q8;
      end else if (y_zero && !x_zero) begin
         push_item.fixed_q8 = xs[vhau_pkg::UV_W-1] ? vhau_pkg::NEG90_Q8 : vhau_pkg::DEG90_Q8;
      end

      // pre-rotate into the right half plane
      push_item.u = u0;
      push_item.v = v0;
      push_item.z = '0;
      if (u0[vhau_pkg::UV_W-1]) begin
         if (!v0[vhau_pkg::UV_W-1]) begin
            push_item.u = v0;
            push_item.v = -u0;
            push_item.z = vhau_pkg::DEG90_Q16;
         end else begin
            push_item.u = -v0;
            push_item.v = u0;
            push_item.z = -vhau_pkg::DEG90_Q16;
         end
      end
   end

endmodule

### hw/rtl/vhau_queue.sv
`timescale 1ns / 1ps

module vhau_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  vhau_pkg::queue_item_type  push_item,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output vhau_pkg::queue_item_type  pop_item
);

   vhau_pkg::queue_item_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("queue pointers disagree with count");

   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd1) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

### hw/rtl/vhau_back.sv
`timescale 1ns / 1ps

module vhau_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pop_valid,
   output logic                      pop_ready,
   input  vhau_pkg::queue_item_type  pop_item,
   vhau_rsp_if.source                rsp_chan
);

   localparam int Steps = vhau_pkg::CORDIC_STEPS;

   vhau_pkg::stage_type stage_ff [Steps+1];
   vhau_pkg::stage_type stage_in [Steps+1];
   logic [Steps:0]      valid_ff;
   logic [Steps:0]      valid_in;
   logic                adv;

   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic signed [vhau_pkg::HEAD_W-1:0] heading_ff;
   logic signed [vhau_pkg::HEAD_W-1:0] heading_in;
   logic                              zero_ff;

   logic signed [vhau_pkg::Z_W-1:0]  zsum;
   logic signed [vhau_pkg::ZR_W-1:0] zr;

   assign adv       = !rsp_valid_ff || rsp_chan.ready;
   assign pop_ready = adv;

   always_comb begin
      stage_in[0].special  = pop_item.special;
      stage_in[0].zero     = pop_item.zero;
      stage_in[0].fixed_q8 = pop_item.fixed_q8;
      stage_in[0].z        = pop_item.z;
      stage_in[0].u = {{(vhau_pkg::DP_W-vhau_pkg::UV_W-vhau_pkg::GUARD_BITS)
                        {pop_item.u[vhau_pkg::UV_W-1]}},
                       pop_item.u, {vhau_pkg::GUARD_BITS{1'b0}}};
      stage_in[0].v = {{(vhau_pkg::DP_W-vhau_pkg::UV_W-vhau_pkg::GUARD_BITS)
                        {pop_item.v[vhau_pkg::UV_W-1]}},
                       pop_item.v, {vhau_pkg::GUARD_BITS{1'b0}}};
   end

   for (genvar i = 0; i < Steps; i++) begin : g_step
      always_comb begin
         logic signed [vhau_pkg::DP_W-1:0] du;
         logic signed [vhau_pkg::DP_W-1:0] dv;
         du = $signed(stage_ff[i].v) >>> i;
         dv = $signed(stage_ff[i].u) >>> i;
         stage_in[i+1] = stage_ff[i];
         if (!stage_ff[i].v[vhau_pkg::DP_W-1]) begin
            stage_in[i+1].u = stage_ff[i].u + du;
            stage_in[i+1].v = stage_ff[i].v - dv;
            stage_in[i+1].z = stage_ff[i].z + vhau_pkg::atan_q16(i);
         end else begin
            stage_in[i+1].u = stage_ff[i].u - du;
            stage_in[i+1].v = stage_ff[i].v + dv;
            stage_in[i+1].z = stage_ff[i].z - vhau_pkg::atan_q16(i);
         end
      end
   end

   for (genvar k = 0; k <= Steps; k++) begin : g_stage_reg
      always_ff @(posedge clock) begin
         if (adv) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (adv) begin
         valid_in = {valid_ff[Steps-1:0], pop_valid};
      end
   end

   // round to Q8 and clamp into (-180, +180]; special items take their fixed heading
   always_comb begin
      zsum = stage_ff[Steps].z + vhau_pkg::ROUND_Q16;
      zr   = zsum[vhau_pkg::Z_W-1:vhau_pkg::DROP_BITS];
      if (stage_ff[Steps].special) begin
         heading_in = stage_ff[Steps].fixed_q8;
      end else if (zr > vhau_pkg::DEG180_Q8) begin
         heading_in = vhau_pkg::DEG180_Q8;
      end else if (zr <= vhau_pkg::NEG180_Q8) begin
         heading_in = vhau_pkg::NEG_SAT_Q8;
      end else begin
         heading_in = zr[vhau_pkg::HEAD_W-1:0];
      end
      rsp_valid_in = adv ? valid_ff[Steps] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         heading_ff <= heading_in;
         zero_ff    <= stage_ff[Steps].zero;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.heading_deg_q8 = heading_ff;
   assign rsp_chan.zero_vector    = zero_ff;

`ifndef NO_ASSERTIONS
   a_last_to_out: assert property (@(posedge clock) disable iff (reset)
      (adv && valid_ff[Steps]) |=> rsp_valid_ff)
      else $error("finished stage did not reach the output");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (heading_ff <= vhau_pkg::DEG180_Q8 &&
                        heading_ff > vhau_pkg::NEG180_Q8))
      else $error("heading out of range");

   a_zero_heading: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && zero_ff) |-> (heading_ff == vhau_pkg::ZERO_Q8))
      else $error("zero vector with nonzero heading");

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipeline moved while output stalled");
`endif

endmodule

### hw/rtl/vector_heading_angle_unit.sv
`timescale 1ns / 1ps

// Heading of a signed 2D vector in degrees, atan2(x, -y), Q8, in (-180, +180].
// req_chan carries x_coord and y_coord; rsp_chan carries heading_deg_q8 and
// zero_vector. Each channel moves one item per transfer when valid and ready
// are both high. The zero vector returns heading 0 with zero_vector set;
// vectors on an axis return exact angles.
// The front classifies each item and pre-rotates it into the right half
// plane, then writes it to a two-entry queue. The back pops the queue into
// a 16-stage CORDIC pipeline followed by a rounding/output register.
// Throughput: one item per cycle while the response side does not stall,
// set by the one-rotation-per-stage pipeline.
// While the receiver holds ready low against a valid response, the output
// register and the whole pipeline hold; the queue fills, req_chan.ready drops.
// Reset (synchronous) empties the queue and the pipeline; no response is
// pending afterward.
module vector_heading_angle_unit (
   input  logic       clock,
   input  logic       reset,
   vhau_req_if.sink   req_chan,
   vhau_rsp_if.source rsp_chan
);

   logic                     push_valid;
   logic                     push_ready;
   vhau_pkg::queue_item_type push_item;
   logic                     pop_valid;
   logic                     pop_ready;
   vhau_pkg::queue_item_type pop_item;

   vhau_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   vhau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   vhau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_chan  (rsp_chan)
   );

endmodule

### sim/tb_vector_heading_angle_unit.sv
`timescale 1ns / 1ps

module tb_vector_heading_angle_unit;

   localparam int  WATCHDOG_LIMIT  = 2000;
   localparam int  RANDOM_VECTORS  = 1050;
   localparam int  SETTLE_CYCLES   = 40;
   localparam int  GUARD_SHIFT     = 20;
   localparam longint QUARTER_Q16  = 5898240;
   localparam longint HALF_TURN_Q8 = 46080;
   localparam longint HALF_ROUND   = 128;

   localparam longint ARC_Q16 [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   typedef logic signed [vhau_pkg::COORD_BITS-1:0] coord_type;
   typedef logic signed [vhau_pkg::HEAD_W-1:0]     heading_type;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      heading_type heading;
      logic        zero;
   } heading_expect_type;

   typedef struct packed {
      coord_type   x;
      coord_type   y;
      logic        typed;
      heading_type heading;
      logic        zero;
   } vector_case_type;

   localparam int DIRECTED_COUNT = 24;
   localparam vector_case_type DIRECTED_CASES [0:DIRECTED_COUNT-1] = '{
      '{16'sd0,      16'sd0,      1'b1, vhau_pkg::ZERO_Q8,   1'b1},
      '{16'sd0,      -16'sd1,     1'b1, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sd0,      16'sh8000,   1'b1, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sd0,      16'sd1,      1'b1, vhau_pkg::DEG180_Q8, 1'b0},
      '{16'sd0,      16'sh7FFF,   1'b1, vhau_pkg::DEG180_Q8, 1'b0},
      '{16'sd1,      16'sd0,      1'b1, vhau_pkg::DEG90_Q8,  1'b0},
      '{16'sh7FFF,   16'sd0,      1'b1, vhau_pkg::DEG90_Q8,  1'b0},
      '{-16'sd1,     16'sd0,      1'b1, vhau_pkg::NEG90_Q8,  1'b0},
      '{16'sh8000,   16'sd0,      1'b1, vhau_pkg::NEG90_Q8,  1'b0},
      '{16'sh8000,   16'sd1,      1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{-16'sd1,     16'sh7FFF,   1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sd1,      16'sh7FFF,   1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sh7FFF,   16'sh7FFF,   1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sh8000,   16'sh8000,   1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sh7FFF,   16'sh8000,   1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sh8000,   16'sh7FFF,   1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sd1,      16'sd1,      1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{-16'sd1,     -16'sd1,     1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sd1,      -16'sd1,     1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{-16'sd1,     16'sd1,      1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sh8000,   -16'sd1,     1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sh7FFF,   16'sd1,      1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{16'sd3,      -16'sd4,     1'b0, vhau_pkg::ZERO_Q8,   1'b0},
      '{-16'sd12345, 16'sd6789,   1'b0, vhau_pkg::ZERO_Q8,   1'b0}
   };

   localparam coord_type EDGE_COORDS [0:5] = '{
      16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF
   };

   logic clock = 1'b0;
   logic reset;

   vhau_req_if req_if ();
   vhau_rsp_if rsp_if ();

   vector_heading_angle_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   heading_expect_type pending_headings [$];
   int                 heading_errors = 0;
   int                 stall_left;
   int                 idle_cycles;
   bit                 send_calm = 1'b0;
   bit                 rsp_calm  = 1'b0;

   function automatic heading_expect_type predict_heading(input coord_type xc,
                                                          input coord_type yc);
      heading_expect_type r;
      longint u, v, z, t, du, dv;
      r.x       = xc;
      r.y       = yc;
      r.heading = '0;
      r.zero    = 1'b0;
      if (xc == 0 && yc == 0) begin
         r.zero = 1'b1;
         return r;
      end
      if (xc == 0) begin
         r.heading = (yc < 0) ? '0 : vhau_pkg::HEAD_W'(HALF_TURN_Q8);
         return r;
      end
      if (yc == 0) begin
         r.heading = (xc > 0) ? vhau_pkg::HEAD_W'(HALF_TURN_Q8 / 2)
                              : vhau_pkg::HEAD_W'(-HALF_TURN_Q8 / 2);
         return r;
      end
      u = -longint'(yc);
      v = longint'(xc);
      z = 0;
      if (u < 0) begin
         if (v >= 0) begin
            t = u;
            u = v;
            v = -t;
            z = QUARTER_Q16;
         end else begin
            t = u;
            u = -v;
            v = t;
            z = -QUARTER_Q16;
         end
      end
      u = u <<< GUARD_SHIFT;
      v = v <<< GUARD_SHIFT;
      for (int i = 0; i < vhau_pkg::CORDIC_STEPS; i++) begin
         du = v >>> i;
         dv = u >>> i;
         if (v >= 0) begin
            u = u + du;
            v = v - dv;
            z = z + ARC_Q16[i];
         end else begin
            u = u - du;
            v = v + dv;
            z = z - ARC_Q16[i];
         end
      end
      z = (z + HALF_ROUND) >>> 8;
      if (z > HALF_TURN_Q8)
         z = HALF_TURN_Q8;
      if (z <= -HALF_TURN_Q8)
         z = -HALF_TURN_Q8 + 1;
      r.heading = z[vhau_pkg::HEAD_W-1:0];
      return r;
   endfunction

   task automatic send_vector(input heading_expect_type want);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 6);
      repeat (gap) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.x_coord <= want.x;
      req_if.y_coord <= want.y;
      do @(posedge clock); while (!req_if.ready);
      pending_headings.push_back(want);
   endtask

   always @(posedge clock) begin
      heading_expect_type want;
      int hold;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         hold = stall_left;
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_headings.size() == 0) begin
               heading_errors++;
               $display("%0t unexpected transfer: heading %0d zero %0b", $time,
                        rsp_if.heading_deg_q8, rsp_if.zero_vector);
            end else begin
               want = pending_headings.pop_front();
               if (rsp_if.heading_deg_q8 !== want.heading) begin
                  heading_errors++;
                  $display("%0t heading mismatch x=%0d y=%0d: expected %0d actual %0d",
                           $time, want.x, want.y, want.heading, rsp_if.heading_deg_q8);
               end
               if (rsp_if.zero_vector !== want.zero) begin
                  heading_errors++;
                  $display("%0t zero_vector mismatch x=%0d y=%0d: expected %0b actual %0b",
                           $time, want.x, want.y, want.zero, rsp_if.zero_vector);
               end
            end
            if ($urandom_range(0, 63) == 0)
               rsp_calm = !rsp_calm;
            hold = rsp_calm ? 0 : $urandom_range(0, 6);
         end else if (hold > 0) begin
            hold--;
         end
         rsp_if.ready <= (hold == 0);
         stall_left   <= hold;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog expired, %0d results outstanding", $time,
                     pending_headings.size());
            $display("vector_heading_angle_unit verification failed");
            $finish;
         end
      end
   end

   initial begin
      heading_expect_type want;
      vector_case_type    row;
      coord_type          xc, yc;
      int                 mag;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.x_coord <= '0;
      req_if.y_coord <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < DIRECTED_COUNT; n++) begin
         row = DIRECTED_CASES[n];
         if (row.typed) begin
            want.x       = row.x;
            want.y       = row.y;
            want.heading = row.heading;
            want.zero    = row.zero;
         end else begin
            want = predict_heading(row.x, row.y);
         end
         send_vector(want);
      end

      for (int n = 0; n < RANDOM_VECTORS; n++) begin
         if (n % 64 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
         if (n == RANDOM_VECTORS / 2) begin
            req_if.valid <= 1'b0;
            do @(posedge clock); while (pending_headings.size() != 0);
         end
         xc = coord_type'($urandom);
         yc = coord_type'($urandom);
         case ($urandom_range(0, 9))
            4: begin
               xc = coord_type'(int'($urandom_range(0, 16)) - 8);
               yc = coord_type'(int'($urandom_range(0, 16)) - 8);
            end
            5: begin
               if ($urandom_range(0, 1))
                  xc = '0;
               else
                  yc = '0;
            end
            6: begin
               xc = coord_type'(int'($urandom_range(0, 8)) - 4);
               yc = coord_type'($urandom_range(1, 32767));
            end
            7: begin
               xc = EDGE_COORDS[$urandom_range(0, 5)];
               yc = EDGE_COORDS[$urandom_range(0, 5)];
            end
            8: begin
               mag = $urandom_range(1, 32767);
               xc  = $urandom_range(0, 1) ? coord_type'(mag) : coord_type'(-mag);
               yc  = $urandom_range(0, 1) ? coord_type'(mag) : coord_type'(-mag);
            end
            9: begin
               if ($urandom_range(0, 3) == 0) begin
                  xc = '0;
                  yc = '0;
               end
            end
            default: ;
         endcase
         send_vector(predict_heading(xc, yc));
      end

      req_if.valid <= 1'b0;
      while (pending_headings.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (heading_errors == 0)
         $display("vector_heading_angle_unit verification clean");
      else
         $display("vector_heading_angle_unit verification failed");
      $finish;
   end

endmodule
